// ----- src/sorted_table_engine_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Sorted table engine assertion macros
// Shared property forms for the sorted table engine checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_ENGINE_UNIT_ASSERT_SVH
`define SORTED_TABLE_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define STE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define STE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ste_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted table engine package
// Sizes, operation and status codes shared by the engine and its table RAM.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int DEPTH  = 64;
  localparam int VAL_W  = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);

  typedef logic [VAL_W-1:0]  value_t;
  typedef logic [IDX_W-1:0]  index_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam func_t FUNC_INSERT     = 3'd0;
  localparam func_t FUNC_REMOVE_VAL = 3'd1;
  localparam func_t FUNC_REMOVE_AT  = 3'd2;
  localparam func_t FUNC_FIND       = 3'd3;
  localparam func_t FUNC_READ       = 3'd4;
  localparam func_t FUNC_CLEAR      = 3'd5;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_FULL      = 2'd1;
  localparam status_t STATUS_NOT_FOUND = 2'd2;
  localparam status_t STATUS_RANGE     = 2'd3;

endpackage

// ----- src/ste_ram.sv -----
// ----------------------------------------------------------------------------
// Sorted table RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ste_ram (
  input  logic            clk,
  input  logic            we,
  input  ste_pkg::index_t waddr,
  input  ste_pkg::value_t wdata,
  input  ste_pkg::index_t raddr,
  output ste_pkg::value_t rdata
);
  import ste_pkg::*;

  value_t mem [DEPTH];
  value_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sorted_table_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted table engine
// Ascending table with insert, remove, find, read and clear requests, run by
// a small sequencer over one RAM.
// ----------------------------------------------------------------------------
//  channel  ports                                   handshake
//  input    in_func, in_key_value, in_slot_position start && !busy
//  result   out_status, out_found_position,         out_valid, one cycle
//           out_entry_value, out_entry_count
//
//  A request that needs no table access is answered from idle. Find stops at
//  its first hit, remove-by-value and any miss walk the whole table, remove-at
//  shifts the entries above its slot down, insert scans and shifts entries
//  above its slot up; the single RAM compares or moves one entry a cycle.
//  Reset is synchronous and empties the table; RAM contents are not cleared.
//  The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_table_engine_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ste_pkg::func_t   in_func,
  input  ste_pkg::value_t  in_key_value,
  input  ste_pkg::count_t  in_slot_position,
  output logic             out_valid,
  output ste_pkg::status_t out_status,
  output ste_pkg::count_t  out_found_position,
  output ste_pkg::value_t  out_entry_value,
  output ste_pkg::count_t  out_entry_count
);
  import ste_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_RDPOS = 3'd2;
  localparam logic [2:0] ST_SHUP  = 3'd3;
  localparam logic [2:0] ST_INSWR = 3'd4;
  localparam logic [2:0] ST_SHDN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  count_t     count_r, count_nxt;
  logic       valid_r, valid_nxt;
  index_t     idx_r, idx_nxt;
  index_t     sh_r, sh_nxt;
  func_t      func_r, func_nxt;
  value_t     key_r, key_nxt;
  value_t     val_r, val_nxt;
  status_t    res_status_r, res_status_nxt;
  count_t     res_pos_r, res_pos_nxt;
  value_t     res_value_r, res_value_nxt;

  logic   ram_we;
  index_t ram_waddr;
  value_t ram_wdata;
  index_t ram_raddr;
  value_t ram_rdata;

  count_t idx_pos;
  logic   scan_last;

  ste_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_pos   = CNT_W'(idx_r) + CNT_W'(1);
  assign scan_last = (idx_pos == count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    valid_nxt      = 1'b0;
    idx_nxt        = idx_r;
    sh_nxt         = sh_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_value_nxt  = res_value_r;
    ram_we         = 1'b0;
    ram_waddr      = sh_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = idx_r + IDX_W'(1);

    case (state_r)
      ST_IDLE: begin
        ram_raddr = '0;
        if (start) begin
          func_nxt       = in_func;
          key_nxt        = in_key_value;
          idx_nxt        = '0;
          res_status_nxt = STATUS_OK;
          res_pos_nxt    = '0;
          res_value_nxt  = '0;
          case (in_func)
            FUNC_INSERT: begin
              if (count_r >= CNT_W'(DEPTH)) begin
                res_status_nxt = STATUS_FULL;
                valid_nxt      = 1'b1;
              end else if (count_r == '0) begin
                state_nxt = ST_INSWR;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            FUNC_REMOVE_VAL, FUNC_FIND: begin
              if (count_r == '0) begin
                res_status_nxt = STATUS_NOT_FOUND;
                valid_nxt      = 1'b1;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            FUNC_REMOVE_AT, FUNC_READ: begin
              if (in_slot_position == '0 || in_slot_position > count_r) begin
                res_status_nxt = STATUS_RANGE;
                valid_nxt      = 1'b1;
              end else begin
                idx_nxt   = IDX_W'(in_slot_position - CNT_W'(1));
                ram_raddr = IDX_W'(in_slot_position - CNT_W'(1));
                state_nxt = ST_RDPOS;
              end
            end
            FUNC_CLEAR: begin
              count_nxt = '0;
              valid_nxt = 1'b1;
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (func_r == FUNC_INSERT) begin
          if (!(key_r > ram_rdata)) begin
            ram_raddr = IDX_W'(count_r - CNT_W'(1));
            sh_nxt    = IDX_W'(count_r);
            state_nxt = ST_SHUP;
          end else if (scan_last) begin
            idx_nxt   = IDX_W'(count_r);
            state_nxt = ST_INSWR;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end else if (key_r == ram_rdata) begin
          res_pos_nxt = idx_pos;
          if (func_r == FUNC_FIND) begin
            valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else if (scan_last) begin
            res_value_nxt = ram_rdata;
            count_nxt     = count_r - CNT_W'(1);
            valid_nxt     = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            val_nxt   = ram_rdata;
            sh_nxt    = idx_r;
            state_nxt = ST_SHDN;
          end
        end else if (scan_last) begin
          res_status_nxt = STATUS_NOT_FOUND;
          valid_nxt      = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_RDPOS: begin
        res_pos_nxt = idx_pos;
        if (func_r == FUNC_READ || scan_last) begin
          res_value_nxt = ram_rdata;
          if (func_r != FUNC_READ) begin
            count_nxt = count_r - CNT_W'(1);
          end
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          val_nxt   = ram_rdata;
          sh_nxt    = idx_r;
          state_nxt = ST_SHDN;
        end
      end
      ST_SHUP: begin
        ram_we    = 1'b1;
        ram_raddr = sh_r - IDX_W'(2);
        if (sh_r == idx_r + IDX_W'(1)) begin
          state_nxt = ST_INSWR;
        end else begin
          sh_nxt = sh_r - IDX_W'(1);
        end
      end
      ST_INSWR: begin
        ram_we      = 1'b1;
        ram_waddr   = idx_r;
        ram_wdata   = key_r;
        count_nxt   = count_r + CNT_W'(1);
        res_pos_nxt = idx_pos;
        valid_nxt   = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_SHDN: begin
        ram_we    = 1'b1;
        ram_raddr = sh_r + IDX_W'(2);
        if (CNT_W'(sh_r) + CNT_W'(2) == count_r) begin
          count_nxt     = count_r - CNT_W'(1);
          res_value_nxt = val_r;
          valid_nxt     = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          sh_nxt = sh_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    sh_r         <= sh_nxt;
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_value_r  <= res_value_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = valid_r;
  assign out_status         = res_status_r;
  assign out_found_position = res_pos_r;
  assign out_entry_value    = res_value_r;
  assign out_entry_count    = count_r;

`include "sorted_table_engine_unit_assert.svh"

  `STE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `STE_ASSERT_NOW(a_idle_no_write, clk, rst_n, !busy, !ram_we, "table written while idle")
  `STE_ASSERT_NOW(a_fail_keeps_count, clk, rst_n, valid_r && res_status_r != STATUS_OK,
                  count_r == $past(count_r), "failed request changed count")
  `STE_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || valid_r,
                   "accepted request neither running nor answered")

endmodule

// ----- dv/sorted_table_engine_unit_test.sv -----
// ----------------------------------------------------------------------------
// Sorted table engine testbench
// Drives insert, remove, find, read, clear and spare-code requests into the
// engine, with bursty gaps on the request side, and predicts each result from
// a local copy of the ascending table. Every result is compared field by field
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sorted_table_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ste_pkg::*;

  localparam int    ITEMS       = 1650;
  localparam int    QUIET_ITEMS = 150;
  localparam int    CYCLE_LIMIT = 600000;
  localparam int    DRAIN_WAIT  = 2 * DEPTH + 16;
  localparam func_t FUNC_SPARE_6 = 3'd6;
  localparam func_t FUNC_SPARE_7 = 3'd7;

  typedef struct packed {
    func_t  func;
    value_t key;
    count_t slot;
  } table_request_t;

  typedef struct packed {
    status_t status;
    count_t  position;
    value_t  value;
    count_t  count;
  } table_answer_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  func_t   in_func = FUNC_INSERT;
  value_t  in_key_value = '0;
  count_t  in_slot_position = '0;
  logic    out_valid;
  status_t out_status;
  count_t  out_found_position;
  value_t  out_entry_value;
  count_t  out_entry_count;

  table_request_t pending[$];
  table_answer_t  answers_due[$];
  value_t         table_vals [DEPTH];
  int             table_fill = 0;
  int             peak_fill = 0;
  bit             took = 1'b0;
  int             gap_left = 0;
  int             gap_pct = 0;
  int             requests_queued = 0;
  int             mismatches = 0;
  int             cycle_count = 0;
  int             func_seen [8];
  int             status_seen [4];

  sorted_table_engine_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_key_value       (in_key_value),
    .in_slot_position   (in_slot_position),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_entry_value    (out_entry_value),
    .out_entry_count    (out_entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic table_answer_t table_apply(func_t f, value_t key, count_t slot);
    table_answer_t a;
    int idx;
    a = '{status: STATUS_OK, position: '0, value: '0, count: '0};
    case (f)
      FUNC_INSERT: begin
        if (table_fill >= DEPTH) begin
          a.status = STATUS_FULL;
        end else begin
          idx = 0;
          while (idx < table_fill && key > table_vals[idx]) idx++;
          for (int i = table_fill; i > idx; i--) table_vals[i] = table_vals[i-1];
          table_vals[idx] = key;
          table_fill++;
          a.position = count_t'(idx + 1);
        end
      end
      FUNC_REMOVE_VAL, FUNC_FIND: begin
        idx = 0;
        while (idx < table_fill && table_vals[idx] != key) idx++;
        if (idx >= table_fill) begin
          a.status = STATUS_NOT_FOUND;
        end else begin
          a.position = count_t'(idx + 1);
          if (f == FUNC_REMOVE_VAL) begin
            a.value = table_vals[idx];
            for (int i = idx; i + 1 < table_fill; i++) table_vals[i] = table_vals[i+1];
            table_fill--;
          end
        end
      end
      FUNC_REMOVE_AT, FUNC_READ: begin
        if (slot == 0 || int'(slot) > table_fill) begin
          a.status = STATUS_RANGE;
        end else begin
          idx = int'(slot) - 1;
          a.position = slot;
          a.value = table_vals[idx];
          if (f == FUNC_REMOVE_AT) begin
            for (int i = idx; i + 1 < table_fill; i++) table_vals[i] = table_vals[i+1];
            table_fill--;
          end
        end
      end
      FUNC_CLEAR: begin
        table_fill = 0;
      end
      default: begin
      end
    endcase
    a.count = count_t'(table_fill);
    if (table_fill > peak_fill) peak_fill = table_fill;
    func_seen[f]++;
    status_seen[a.status]++;
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // request driver
  always @(negedge clk) begin
    table_request_t req;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // hold until the engine takes it
    end else if (gap_left != 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
    end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap_left = $urandom_range(0, 7);
      start <= 1'b0;
    end else if (pending.size() != 0) begin
      req = pending.pop_front();
      start <= 1'b1;
      in_func <= req.func;
      in_key_value <= req.key;
      in_slot_position <= req.slot;
    end else begin
      start <= 1'b0;
    end
  end

  // result monitor and predictor feed
  always @(posedge clk) begin
    table_answer_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
      $display("FAIL sorted_table_engine_unit");
      $finish;
    end else if (!rst_n) begin
      took = 1'b0;
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result with no request outstanding", out_status, '0);
        end else begin
          want = answers_due.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_found_position !== want.position)
            report_mismatch("position", out_found_position, want.position);
          if (out_entry_value !== want.value)
            report_mismatch("value", out_entry_value, want.value);
          if (out_entry_count !== want.count)
            report_mismatch("count", out_entry_count, want.count);
        end
      end
      took = start && !busy;
      if (took) answers_due.push_back(table_apply(in_func, in_key_value, in_slot_position));
    end
  end

  task automatic queue_request(func_t f, value_t key, count_t slot);
    if (requests_queued >= ITEMS - QUIET_ITEMS) gap_pct = 0;
    while (pending.size() >= 2) @(posedge clk);
    pending.push_back('{func: f, key: key, slot: slot});
    requests_queued++;
  endtask

  function automatic value_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && table_fill > 0) return table_vals[$urandom_range(0, table_fill - 1)];
    if (r < 60) return value_t'($urandom_range(0, 12));
    if (r < 70) return ($urandom_range(0, 1) == 1) ? '1 : value_t'(32'h8000_0000);
    return value_t'($urandom);
  endfunction

  function automatic count_t pick_slot();
    if ($urandom_range(0, 4) == 0) return count_t'($urandom_range(0, 127));
    return count_t'($urandom_range(1, (table_fill > 0) ? table_fill : 1));
  endfunction

  task automatic run_segment();
    int kind, len, r;
    kind = $urandom_range(0, 9);
    len = $urandom_range(8, 60);
    gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
    if (kind < 2) begin
      len = DEPTH - table_fill + $urandom_range(1, 6);
      repeat (len) queue_request(FUNC_INSERT, pick_key(), pick_slot());
    end else if (kind < 4) begin
      repeat (len) begin
        if ($urandom_range(0, 1) == 1) queue_request(FUNC_REMOVE_AT, pick_key(), pick_slot());
        else queue_request(FUNC_REMOVE_VAL, pick_key(), pick_slot());
      end
    end else if (kind < 9) begin
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 30) queue_request(FUNC_INSERT, pick_key(), pick_slot());
        else if (r < 45) queue_request(FUNC_REMOVE_VAL, pick_key(), pick_slot());
        else if (r < 60) queue_request(FUNC_REMOVE_AT, pick_key(), pick_slot());
        else if (r < 75) queue_request(FUNC_FIND, pick_key(), pick_slot());
        else if (r < 98) queue_request(FUNC_READ, pick_key(), pick_slot());
        else queue_request(FUNC_CLEAR, pick_key(), pick_slot());
      end
    end else begin
      repeat (len) queue_request(func_t'($urandom_range(0, 7)), value_t'($urandom),
                                 count_t'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_request(FUNC_READ,       '0,              count_t'(1));
    queue_request(FUNC_REMOVE_AT,  '0,              count_t'(0));
    queue_request(FUNC_FIND,       '0,              count_t'(1));
    queue_request(FUNC_REMOVE_VAL, value_t'(7),     count_t'(1));
    queue_request(FUNC_CLEAR,      '0,              count_t'(0));
    queue_request(FUNC_INSERT,     '1,              count_t'(127));
    queue_request(FUNC_INSERT,     '0,              count_t'(0));
    queue_request(FUNC_INSERT,     value_t'(5),     count_t'(1));
    queue_request(FUNC_INSERT,     value_t'(5),     count_t'(1));
    queue_request(FUNC_INSERT,     32'hAAAA_AAAA,   count_t'(1));
    queue_request(FUNC_INSERT,     32'h5555_5555,   count_t'(1));
    queue_request(FUNC_FIND,       value_t'(5),     count_t'(1));
    queue_request(FUNC_READ,       '0,              count_t'(1));
    queue_request(FUNC_READ,       '0,              count_t'(6));
    queue_request(FUNC_READ,       '0,              count_t'(7));
    queue_request(FUNC_READ,       '1,              count_t'(127));
    queue_request(FUNC_REMOVE_AT,  '0,              count_t'(0));
    queue_request(FUNC_REMOVE_AT,  '0,              count_t'(6));
    queue_request(FUNC_REMOVE_VAL, value_t'(5),     count_t'(1));
    queue_request(FUNC_SPARE_6,    '1,              count_t'(3));
    queue_request(FUNC_SPARE_7,    value_t'(5),     count_t'(1));
    queue_request(FUNC_FIND,       '1,              count_t'(1));
    queue_request(FUNC_REMOVE_AT,  '0,              count_t'(1));
    queue_request(FUNC_CLEAR,      '0,              count_t'(0));
    queue_request(FUNC_READ,       '0,              count_t'(1));

    while (requests_queued < ITEMS) run_segment();

    do @(negedge clk);
    while (pending.size() != 0 || (start && !took) || answers_due.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (answers_due.size() != 0)
      report_mismatch("requests left without result", answers_due.size(), '0);
    $display("requests: insert %0d, remove-by-value %0d, remove-at %0d, find %0d, read %0d,",
             func_seen[FUNC_INSERT], func_seen[FUNC_REMOVE_VAL], func_seen[FUNC_REMOVE_AT],
             func_seen[FUNC_FIND], func_seen[FUNC_READ]);
    $display("clear %0d, spare %0d; ok %0d, full %0d, missing %0d, out of range %0d, peak %0d",
             func_seen[FUNC_CLEAR], func_seen[FUNC_SPARE_6] + func_seen[FUNC_SPARE_7],
             status_seen[STATUS_OK], status_seen[STATUS_FULL], status_seen[STATUS_NOT_FOUND],
             status_seen[STATUS_RANGE], peak_fill);
    if (mismatches == 0) begin
      $display("PASS sorted_table_engine_unit");
    end else begin
      $display("FAIL sorted_table_engine_unit");
    end
    $finish;
  end

endmodule
